/* src/pred_pkg.sv */
package pred_pkg;

    localparam int WORD_W      = 32;
    localparam int EVENT_W     = 24;
    localparam int CHANNEL_W   = 6;
    localparam int CHIP_W      = 5;
    localparam int DCOL_W      = 5;
    localparam int COLUMN_W    = 6;
    localparam int ROW_W       = 7;
    localparam int PULSE_W     = 8;
    localparam int KIND_W      = 2;
    localparam int S_DATA_W    = 2 * WORD_W;
    localparam int M_DATA_W    = 56;

    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRAILER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HIT     = 2'd2;

    localparam logic [7:0]           HEADER_MARK  = 8'h50;
    localparam logic [3:0]           TRAILER_MARK = 4'hA;
    localparam logic [CHIP_W-1:0]    CHIP_MAX     = 5'd25;
    localparam logic [CHANNEL_W-1:0] CHANNEL_MIN  = 6'd1;
    localparam logic [CHANNEL_W-1:0] CHANNEL_MAX  = 6'd36;
    localparam logic [ROW_W-1:0]     ROW_ODD_MID  = 7'd80;
    localparam logic [ROW_W-1:0]     ROW_EVEN_MID = 7'd81;

    typedef struct packed {
        logic                 valid;
        logic [CHANNEL_W-1:0] channel;
        logic [CHIP_W-1:0]    chip_id;
        logic [COLUMN_W-1:0]  column;
        logic [ROW_W-1:0]     row;
        logic [PULSE_W-1:0]   pulse;
    } hit_t;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [EVENT_W-1:0]   event_id;
        logic [CHANNEL_W-1:0] channel;
        logic [CHIP_W-1:0]    chip_id;
        logic [COLUMN_W-1:0]  column;
        logic [ROW_W-1:0]     row;
        logic [PULSE_W-1:0]   pulse;
        logic                 last;
    } result_t;

endpackage

/* src/pred_lane.sv */
module pred_lane
(
    input  logic [pred_pkg::WORD_W-1:0] half,
    output pred_pkg::hit_t              hit
);
    import pred_pkg::*;

    logic [CHANNEL_W-1:0] channel;
    logic [CHIP_W-1:0]    chip_id;
    logic [DCOL_W-1:0]    dcol;
    logic [ROW_W-1:0]     half_code;
    logic                 odd;
    logic                 positive;
    logic [ROW_W-1:0]     row;

    assign channel   = half[31:26];
    assign chip_id   = half[25:21];
    assign dcol      = half[20:16];
    assign half_code = half[15:9];
    assign odd       = half[8];

    always_comb
    begin
        if (odd)
        begin
            positive = (half_code < ROW_ODD_MID);
            row      = positive ? (ROW_ODD_MID - half_code) : (half_code - ROW_ODD_MID);
        end
        else if (half_code == '0)
        begin
            positive = 1'b0;
            row      = ROW_ODD_MID;
        end
        else
        begin
            positive = (half_code > ROW_EVEN_MID);
            row      = positive ? (half_code - ROW_EVEN_MID) : (ROW_EVEN_MID - half_code);
        end
    end

    always_comb
    begin
        hit.valid   = (half[27:0] != '0) && (chip_id <= CHIP_MAX)
                      && (channel >= CHANNEL_MIN) && (channel <= CHANNEL_MAX);
        hit.channel = channel;
        hit.chip_id = chip_id;
        hit.column  = {dcol, positive};
        hit.row     = row;
        hit.pulse   = half[7:0];
    end

endmodule

/* src/pred_merge.sv */
module pred_merge
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [pred_pkg::WORD_W-1:0] high_half,
    input  pred_pkg::hit_t              hit_lo,
    input  pred_pkg::hit_t              hit_hi,
    output pred_pkg::result_t           res0,
    output pred_pkg::result_t           res1,
    output logic [1:0]                  res_count
);
    import pred_pkg::*;

    logic               in_event_reg;
    logic               in_event_next;
    logic [EVENT_W-1:0] current_event_reg;
    logic [EVENT_W-1:0] current_event_next;
    logic               is_header;
    logic               is_trailer;
    logic               is_data;
    hit_t               first_hit;

    assign is_header  = !in_event_reg && (high_half[31:24] == HEADER_MARK);
    assign is_trailer = in_event_reg && (high_half[31:28] == TRAILER_MARK);
    assign is_data    = in_event_reg && !is_trailer;
    assign first_hit  = hit_lo.valid ? hit_lo : hit_hi;

    always_comb
    begin
        res0      = '0;
        res1      = '0;
        res_count = 2'd0;
        if (is_header)
        begin
            res0.kind     = KIND_HEADER;
            res0.event_id = high_half[EVENT_W-1:0];
            res0.last     = 1'b1;
            res_count     = 2'd1;
        end
        else if (is_trailer)
        begin
            res0.kind     = KIND_TRAILER;
            res0.event_id = current_event_reg;
            res0.last     = 1'b1;
            res_count     = 2'd1;
        end
        else if (is_data)
        begin
            res0.kind     = KIND_HIT;
            res0.event_id = current_event_reg;
            res0.channel  = first_hit.channel;
            res0.chip_id  = first_hit.chip_id;
            res0.column   = first_hit.column;
            res0.row      = first_hit.row;
            res0.pulse    = first_hit.pulse;
            res0.last     = !(hit_lo.valid && hit_hi.valid);
            res1.kind     = KIND_HIT;
            res1.event_id = current_event_reg;
            res1.channel  = hit_hi.channel;
            res1.chip_id  = hit_hi.chip_id;
            res1.column   = hit_hi.column;
            res1.row      = hit_hi.row;
            res1.pulse    = hit_hi.pulse;
            res1.last     = 1'b1;
            res_count     = {1'b0, hit_lo.valid} + {1'b0, hit_hi.valid};
        end
    end

    always_comb
    begin
        in_event_next      = in_event_reg;
        current_event_next = current_event_reg;
        if (accept && is_header)
        begin
            in_event_next      = 1'b1;
            current_event_next = high_half[EVENT_W-1:0];
        end
        else if (accept && is_trailer)
        begin
            in_event_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_event_reg      <= 1'b0;
            current_event_reg <= '0;
        end
        else
        begin
            in_event_reg      <= in_event_next;
            current_event_reg <= current_event_next;
        end
    end

`ifndef SYNTHESIS
    a_header_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_header |=> in_event_reg
            && (current_event_reg == $past(high_half[EVENT_W-1:0])))
        else $error("header did not open an event");
    a_trailer_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_trailer |=> !in_event_reg)
        else $error("trailer did not close the event");
    a_pair_only_in_event: assert property (@(posedge clk) disable iff (!rst_n)
        (res_count == 2'd2) |-> (in_event_reg && hit_lo.valid && hit_hi.valid))
        else $error("two results outside a data word");
    a_event_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_event_reg && $past(in_event_reg) |-> $stable(current_event_reg))
        else $error("event number changed inside an event");
`endif

endmodule

/* src/pixel_readout_event_decoder_top.sv */
// A result is written into a four-entry result buffer when its word is accepted
// and is shown on the master side from there. One word per cycle is taken while
// each word gives at most one result and the master side takes results; a word
// with two hits fills the buffer faster than the single-result output port drains
// it. A word is taken only while at least two entries are free. Reset (rst_n low,
// asynchronous) leaves the event, clears the event number and empties the buffer.
module pixel_readout_event_decoder_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // low_half [31:0], high_half [63:32]
    input  logic [pred_pkg::S_DATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // event_id [23:0], channel [29:24], chip_id [34:30], column [40:35],
    // row [47:41], pulse [55:48]
    output logic [pred_pkg::M_DATA_W-1:0] m_axis_tdata,
    // kind [1:0]
    output logic [pred_pkg::KIND_W-1:0]   m_axis_tuser,
    output logic                          m_axis_tlast
);
    import pred_pkg::*;

    logic [WORD_W-1:0] low_half;
    logic [WORD_W-1:0] high_half;
    hit_t              hit_lo;
    hit_t              hit_hi;
    result_t           res0;
    result_t           res1;
    logic [1:0]        res_count;
    logic              accept;
    logic              pop;
    logic [1:0]        push_n;

    result_t           queue_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    result_t           head;

    assign low_half  = s_axis_tdata[WORD_W-1:0];
    assign high_half = s_axis_tdata[S_DATA_W-1:WORD_W];

    pred_lane u_lane_lo
    (
        .half (low_half),
        .hit  (hit_lo)
    );

    pred_lane u_lane_hi
    (
        .half (high_half),
        .hit  (hit_hi)
    );

    pred_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .high_half (high_half),
        .hit_lo    (hit_lo),
        .hit_hi    (hit_hi),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    assign s_axis_tready = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (count_reg != '0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign push_n        = accept ? res_count : 2'd0;

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2)
        begin
            queue_reg[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head = queue_reg[rd_ptr_reg];

    assign m_axis_tdata = {head.pulse, head.row, head.column, head.chip_id,
                           head.channel, head.event_id};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result buffer overrun");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != CNT_W'(FIFO_DEPTH)) |-> (PTR_W'(count_reg) == (wr_ptr_reg - rd_ptr_reg)))
        else $error("buffer pointers disagree with fill level");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (res_count == 2'd2) && !pop |=> count_reg == $past(count_reg) + CNT_W'(2))
        else $error("two results not both queued");
`endif

endmodule

/* tb/pixel_readout_event_decoder_top_tb.sv */
module pixel_readout_event_decoder_top_tb;

    import pred_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 250;
    localparam int MAX_REPORTS = 10;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic [KIND_W-1:0]     m_axis_tuser;
    logic                  m_axis_tlast;

    bit                    ev_open = 1'b0;
    logic [EVENT_W-1:0]    ev_number = '0;
    result_t               pending_results[$];
    int                    active_words = 0;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    hold_req = 0;
    int                    hold_left = 0;
    int                    mismatches = 0;
    int                    quiet_cycles = 0;
    result_t               seen;

    pixel_readout_event_decoder_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic [WORD_W-1:0] hit_word(input int ch, input int chip,
                                                   input int dcol, input int pix,
                                                   input int ph);
        return {ch[CHANNEL_W-1:0], chip[CHIP_W-1:0], dcol[DCOL_W-1:0], pix[7:0],
                ph[PULSE_W-1:0]};
    endfunction

    function automatic bit decode_hit(input logic [WORD_W-1:0] w, output result_t r);
        int pix;
        int f;
        int mag;
        r = '0;
        if (w[27:0] == '0)
            return 1'b0;
        if (w[25:21] > CHIP_MAX)
            return 1'b0;
        if (w[31:26] < CHANNEL_MIN || w[31:26] > CHANNEL_MAX)
            return 1'b0;
        pix = int'(w[15:8]);
        if (pix[0])
            f = int'(ROW_ODD_MID) - (pix - 1) / 2;
        else
            f = (pix - 1) / 2 - int'(ROW_ODD_MID);
        mag = (f < 0) ? -f : f;
        r.kind     = KIND_HIT;
        r.event_id = ev_number;
        r.channel  = w[31:26];
        r.chip_id  = w[25:21];
        r.column   = {w[20:16], (f > 0) ? 1'b1 : 1'b0};
        r.row      = mag[ROW_W-1:0];
        r.pulse    = w[7:0];
        return 1'b1;
    endfunction

    task automatic decode_word(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
        result_t res [2];
        int      n;
        int      i;
        bit      was_open;
        n        = 0;
        was_open = ev_open;
        res[0]   = '0;
        res[1]   = '0;
        if (!ev_open)
        begin
            if (hi[31:24] == HEADER_MARK)
            begin
                ev_number       = hi[EVENT_W-1:0];
                ev_open         = 1'b1;
                res[0].kind     = KIND_HEADER;
                res[0].event_id = ev_number;
                n               = 1;
            end
        end
        else if (hi[31:28] == TRAILER_MARK)
        begin
            ev_open         = 1'b0;
            res[0].kind     = KIND_TRAILER;
            res[0].event_id = ev_number;
            n               = 1;
        end
        else
        begin
            if (decode_hit(lo, res[n]))
                n++;
            if (decode_hit(hi, res[n]))
                n++;
        end
        if (n > 0)
            res[n-1].last = 1'b1;
        for (i = 0; i < n; i++)
            pending_results.push_back(res[i]);
        if (was_open || n > 0)
            active_words++;
    endtask

    task automatic send_word(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hi, lo};
        do
            @(posedge clk);
        while (!s_axis_tready);
        decode_word(lo, hi);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    function automatic logic [WORD_W-1:0] random_half();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return hit_word($urandom_range(36, 1), $urandom_range(25, 0), $urandom, $urandom,
                            $urandom);
        if (r < 82)
            return hit_word($urandom, $urandom_range(31, 26), $urandom, $urandom, $urandom);
        if (r < 88)
            return hit_word(r[0] ? 0 : $urandom_range(63, 37), $urandom, $urandom, $urandom,
                            $urandom);
        if (r < 93)
            return '1;
        if (r < 97)
            return {4'($urandom), 28'd0};
        return $urandom;
    endfunction

    task automatic compare_result(input result_t want, input result_t got);
        string bad;
        bad = "";
        if (got.kind !== want.kind)         bad = {bad, " kind"};
        if (got.event_id !== want.event_id) bad = {bad, " event_id"};
        if (got.channel !== want.channel)   bad = {bad, " channel"};
        if (got.chip_id !== want.chip_id)   bad = {bad, " chip_id"};
        if (got.column !== want.column)     bad = {bad, " column"};
        if (got.row !== want.row)           bad = {bad, " row"};
        if (got.pulse !== want.pulse)       bad = {bad, " pulse"};
        if (got.last !== want.last)         bad = {bad, " last"};
        if (bad != "")
        begin
            if (mismatches < MAX_REPORTS)
            begin
                $display("mismatch in%s", bad);
                $display("  expected kind=%0d ev=%h ch=%0d chip=%0d col=%0d row=%0d ph=%0d last=%0b",
                         want.kind, want.event_id, want.channel, want.chip_id, want.column,
                         want.row, want.pulse, want.last);
                $display("  actual   kind=%0d ev=%h ch=%0d chip=%0d col=%0d row=%0d ph=%0d last=%0b",
                         got.kind, got.event_id, got.channel, got.chip_id, got.column,
                         got.row, got.pulse, got.last);
            end
            mismatches++;
        end
    endtask

    // hold off the result stream when asked, otherwise stall at random
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.kind     = m_axis_tuser;
            seen.event_id = m_axis_tdata[23:0];
            seen.channel  = m_axis_tdata[29:24];
            seen.chip_id  = m_axis_tdata[34:30];
            seen.column   = m_axis_tdata[40:35];
            seen.row      = m_axis_tdata[47:41];
            seen.pulse    = m_axis_tdata[55:48];
            seen.last     = m_axis_tlast;
            if (pending_results.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result kind=%0d ev=%h", seen.kind, seen.event_id);
                mismatches++;
            end
            else
                compare_result(pending_results.pop_front(), seen);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_directed_words();
        send_idle_pct = 33;
        recv_idle_pct = 88;
        // drop data and trailer outside an event
        send_word(hit_word(7, 3, 4, 9, 'h55), hit_word(8, 2, 1, 5, 'hAA));
        send_word(32'h0, {TRAILER_MARK, 28'd0});
        send_word('1, {HEADER_MARK, 24'h000000});
        send_word(hit_word(1, 0, 0, 0, 0), hit_word(36, 25, 31, 255, 255));
        send_word(hit_word(5, 3, 7, 1, 'h12), hit_word(9, 1, 2, 2, 'h34));
        send_word(hit_word(2, 2, 4, 161, 'h01), hit_word(3, 4, 5, 162, 'h80));
        send_word(hit_word(4, 0, 0, 160, 'h7F), hit_word(6, 0, 0, 163, 'hFE));
        send_word(hit_word(10, 26, 3, 3, 'h11), hit_word(11, 12, 13, 14, 'h22));
        send_word(hit_word(12, 5, 6, 77, 'h33), hit_word(13, 31, 2, 2, 'h44));
        send_word(hit_word(0, 5, 6, 7, 'h08), hit_word(37, 5, 6, 7, 'h09));
        send_word('1, '1);
        send_word({6'd12, 26'd0}, 32'h1000_0000);
        // header mark inside an event is plain data
        send_word(hit_word(14, 7, 9, 100, 'h5A), {HEADER_MARK, 24'h123456});
        send_word(hit_word(15, 8, 10, 101, 'hA5), {TRAILER_MARK, 28'hFFF_FFFF});
        send_word(32'h0, {HEADER_MARK, 24'hFFFFFF});
        send_word(hit_word(36, 25, 0, 254, 'hC3), hit_word(36, 25, 31, 253, 'h3C));
        send_word('1, {TRAILER_MARK, 28'd0});
        send_word($urandom, {HEADER_MARK, 24'hABCDEF});
        send_word(32'h0, {TRAILER_MARK, 28'h0123456});
        wait_drain();
    endtask

    task automatic test_random_traffic(input int words, input int send_pct, input int recv_pct);
        int                 goal;
        int                 r;
        int                 k;
        logic [EVENT_W-1:0] id;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        goal = active_words + words;
        while (active_words < goal)
        begin
            r = $urandom_range(99);
            if (r < 8)
                send_word($urandom, $urandom);
            else
            begin
                k  = $urandom_range(9);
                id = (k == 0) ? '0 : (k == 1) ? '1 : EVENT_W'($urandom);
                send_word($urandom, {HEADER_MARK, id});
                repeat ($urandom_range(6, 0))
                begin
                    if ($urandom_range(99) < 5)
                        send_word(random_half(), {HEADER_MARK, EVENT_W'($urandom)});
                    else
                        send_word(random_half(), random_half());
                end
                if (r < 96)
                    send_word($urandom, {TRAILER_MARK, 28'($urandom)});
                if (r >= 94)
                    send_word($urandom, {TRAILER_MARK, 28'($urandom)});
            end
        end
        wait_drain();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        if (ev_open)
            send_word(32'h0, {TRAILER_MARK, 28'd0});
        send_word($urandom, {HEADER_MARK, EVENT_W'($urandom)});
        hold_req = HOLD_CYCLES;
        repeat (20)
            send_word(hit_word($urandom_range(36, 1), $urandom_range(25, 0), $urandom,
                               $urandom, $urandom_range(255, 1)),
                      hit_word($urandom_range(36, 1), $urandom_range(25, 0), $urandom,
                               $urandom, $urandom_range(255, 1)));
        send_word($urandom, {TRAILER_MARK, 28'($urandom)});
        wait_drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_words();
        test_random_traffic(180, 33, 88);
        test_random_traffic(180, 88, 33);
        test_random_traffic(170, 0, 0);
        test_output_backpressure();
        wait_drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
src/pred_pkg.sv
src/pred_lane.sv
src/pred_merge.sv
src/pixel_readout_event_decoder_top.sv
tb/pixel_readout_event_decoder_top_tb.sv
